// ===== rtl/hff_pkg.sv =====
// ----------------------------------------------------------------------------
// hff_pkg
// Shared types, widths, character codes and helpers for the hex float
// text formatter.
// ----------------------------------------------------------------------------
`default_nettype none

package hff_pkg;

  localparam int VALUE_W     = 64;
  localparam int PREC_W      = 7;
  localparam int CHAR_W      = 8;
  localparam int FRAC_BITS   = 52;
  localparam int EXP_BITS    = 11;
  localparam int FRAC_DIGITS = 13;
  localparam int COEFF_W     = 54;
  localparam int EMAG_W      = 10;
  localparam int BCD_W       = 16;
  localparam int DABBLE_W    = 4;

  localparam logic [EXP_BITS-1:0] EXP_SPECIAL = 11'h7FF;
  localparam logic [EXP_BITS-1:0] EXP_BIAS    = 11'd1023;

  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_POINT = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_LX    = 8'h78;
  localparam logic [CHAR_W-1:0] CH_UX    = 8'h58;
  localparam logic [CHAR_W-1:0] CH_LP    = 8'h70;
  localparam logic [CHAR_W-1:0] CH_UP    = 8'h50;
  localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
  localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
  localparam logic [CHAR_W-1:0] CH_I     = 8'h69;
  localparam logic [CHAR_W-1:0] CH_N     = 8'h6E;
  localparam logic [CHAR_W-1:0] CH_F     = 8'h66;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CONV,
    ST_SIGN,
    ST_SPEC0,
    ST_SPEC1,
    ST_SPEC2,
    ST_ZERO,
    ST_X,
    ST_LEAD,
    ST_POINT,
    ST_FRAC,
    ST_P,
    ST_ESIGN,
    ST_EDIG
  } state_t;

  // ascii for one hex (or decimal) digit
  function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] nyb, input logic upper);
    logic [CHAR_W-1:0] r;
    if (nyb < 4'd10) begin
      r = CH_ZERO + CHAR_W'(nyb);
    end else if (upper) begin
      r = CH_UA + CHAR_W'(nyb - 4'd10);
    end else begin
      r = CH_LA + CHAR_W'(nyb - 4'd10);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/hff_item_if.sv =====
// ----------------------------------------------------------------------------
// hff_item_if
// Request channel: one binary64 pattern and its format options.
// ----------------------------------------------------------------------------
`default_nettype none

interface hff_item_if;
  import hff_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [VALUE_W-1:0]        value_bits;
  logic signed [PREC_W-1:0]  precision;
  logic                      force_point;
  logic                      upper_case;

  modport source (
    output valid, value_bits, precision, force_point, upper_case,
    input  ready
  );

  modport sink (
    input  valid, value_bits, precision, force_point, upper_case,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/hff_text_if.sv =====
// ----------------------------------------------------------------------------
// hff_text_if
// Character channel: one ascii character per request, last flags the end.
// ----------------------------------------------------------------------------
`default_nettype none

interface hff_text_if;
  import hff_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_out;
  logic              last;

  modport source (
    output valid, char_out, last,
    input  ready
  );

  modport sink (
    input  valid, char_out, last,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/hex_float_text_formatter_top.sv =====
// ----------------------------------------------------------------------------
// hex_float_text_formatter_top
// Formats a binary64 bit pattern as printf %a text, one character per request.
// ----------------------------------------------------------------------------
// A value is taken on the item channel only while the formatter is idle. It
// then runs a shift-add-3 binary to decimal loop that turns the exponent
// magnitude into bcd digits (the coefficient is rounded in the first step of
// that loop), and after that puts out one character per cycle, while the text
// side does not stall, through a single output register. The text of one
// value holds N characters, with N from 3 to 5 + MAX_PRECISION + 6. The next
// value is accepted the cycle after its last character has been loaded
// into the output register, while that character may still be waiting to
// be taken.
// ----------------------------------------------------------------------------
`default_nettype none

module hex_float_text_formatter_top #(
  parameter int MAX_PRECISION = 50
) (
  input  wire         clk,
  input  wire         rst,
  hff_item_if.sink    item,
  hff_text_if.source  text
);
  import hff_pkg::*;

  localparam int CW = $clog2(MAX_PRECISION + 1);

  // sequencer state
  state_t state, state_next;

  // per-value context
  logic                neg, neg_next;
  logic                special, special_next;
  logic                is_nan, is_nan_next;
  logic                upper, upper_next;
  logic                fpt, fpt_next;
  logic                shortest, shortest_next;
  logic [CW-1:0]       cnt, cnt_next;
  logic [COEFF_W-1:0]  coeff, coeff_next;

  // exponent conversion
  logic                eneg, eneg_next;
  logic [EMAG_W-1:0]   emag, emag_next;
  logic [BCD_W-1:0]    bcd, bcd_next;
  logic [DABBLE_W-1:0] cc, cc_next;
  logic [1:0]          ecnt, ecnt_next;

  // output register
  logic                out_valid, out_valid_next;
  logic [CHAR_W-1:0]   out_char, out_char_next;
  logic                out_last, out_last_next;

  // helpers
  logic [EXP_BITS-1:0]  bexp;
  logic                 mant_nz;
  logic                 slot_free;
  logic                 frac_nz;
  logic                 has_digits;
  logic                 show_point;
  logic [3:0]           rnd_nyb;
  logic [COEFF_W-1:0]   rnd_inc;
  logic [BCD_W-1:0]     bcd_adj;
  logic [3:0]           dig;

  assign item.ready     = (state == ST_IDLE);
  assign text.valid     = out_valid;
  assign text.char_out  = out_char;
  assign text.last      = out_last;

  assign bexp       = item.value_bits[VALUE_W-2 -: EXP_BITS];
  assign mant_nz    = (item.value_bits[FRAC_BITS-1:0] != '0);
  assign slot_free  = !out_valid || text.ready;
  assign frac_nz    = (coeff[FRAC_BITS-1:0] != '0);
  assign has_digits = shortest ? frac_nz : (cnt != '0);
  assign show_point = fpt || has_digits;

  // round half-up on the first nybble cut off, only for 0..12 digits
  always_comb begin
    rnd_nyb = '0;
    rnd_inc = '0;
    for (int p = 0; p < FRAC_DIGITS; p++) begin
      if (cnt == CW'(p)) begin
        rnd_nyb = coeff[4*(FRAC_DIGITS-1-p) +: 4];
        rnd_inc = COEFF_W'(1) << (4 * (FRAC_DIGITS - p));
      end
    end
  end

  // one shift-add-3 step: bump each bcd digit of 5 or more by 3
  always_comb begin
    for (int d = 0; d < 4; d++) begin
      dig = bcd[4*d +: 4];
      bcd_adj[4*d +: 4] = (dig >= 4'd5) ? dig + 4'd3 : dig;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    neg      <= neg_next;
    special  <= special_next;
    is_nan   <= is_nan_next;
    upper    <= upper_next;
    fpt      <= fpt_next;
    shortest <= shortest_next;
    cnt      <= cnt_next;
    coeff    <= coeff_next;
    eneg     <= eneg_next;
    emag     <= emag_next;
    bcd      <= bcd_next;
    cc       <= cc_next;
    ecnt     <= ecnt_next;
    out_char <= out_char_next;
    out_last <= out_last_next;
  end

  always_comb begin
    state_next     = state;
    neg_next       = neg;
    special_next   = special;
    is_nan_next    = is_nan;
    upper_next     = upper;
    fpt_next       = fpt;
    shortest_next  = shortest;
    cnt_next       = cnt;
    coeff_next     = coeff;
    eneg_next      = eneg;
    emag_next      = emag;
    bcd_next       = bcd;
    cc_next        = cc;
    ecnt_next      = ecnt;
    out_valid_next = out_valid && !text.ready;
    out_char_next  = out_char;
    out_last_next  = out_last;

    case (state)
      ST_IDLE: begin
        if (item.valid) begin
          neg_next     = item.value_bits[VALUE_W-1];
          special_next = (bexp == EXP_SPECIAL);
          is_nan_next  = mant_nz;
          upper_next   = item.upper_case;
          fpt_next     = item.force_point;
          coeff_next   = {1'b0, (bexp != '0), item.value_bits[FRAC_BITS-1:0]};
          // negative precision means shortest exact, large values clamp
          if (item.precision[PREC_W-1]) begin
            shortest_next = 1'b1;
            cnt_next      = '0;
          end else if (item.precision[PREC_W-2:0] > (PREC_W-1)'(MAX_PRECISION)) begin
            shortest_next = 1'b0;
            cnt_next      = CW'(MAX_PRECISION);
          end else begin
            shortest_next = 1'b0;
            cnt_next      = CW'(item.precision[PREC_W-2:0]);
          end
          // exponent sign and magnitude; zero prints +0, subnormals -1023
          if (bexp == '0) begin
            eneg_next = mant_nz;
            emag_next = mant_nz ? EMAG_W'(EXP_BIAS) : '0;
          end else if (bexp >= EXP_BIAS) begin
            eneg_next = 1'b0;
            emag_next = EMAG_W'(bexp - EXP_BIAS);
          end else begin
            eneg_next = 1'b1;
            emag_next = EMAG_W'(EXP_BIAS - bexp);
          end
          bcd_next   = '0;
          cc_next    = '0;
          state_next = ST_CONV;
        end
      end

      ST_CONV: begin
        // coefficient rounding rides on the first conversion cycle
        if (cc == '0 && !shortest && cnt < CW'(FRAC_DIGITS) && rnd_nyb >= 4'h8) begin
          coeff_next = coeff + rnd_inc;
        end
        bcd_next  = {bcd_adj[BCD_W-2:0], emag[EMAG_W-1]};
        emag_next = {emag[EMAG_W-2:0], 1'b0};
        cc_next   = cc + 1'b1;
        if (cc == DABBLE_W'(EMAG_W - 1)) begin
          if (neg) begin
            state_next = ST_SIGN;
          end else if (special) begin
            state_next = ST_SPEC0;
          end else begin
            state_next = ST_ZERO;
          end
        end
      end

      ST_SIGN: begin
        if (slot_free) begin
          out_valid_next = 1'b1;
          out_char_next  = CH_MINUS;
          out_last_next  = 1'b0;
          state_next     = special ? ST_SPEC0 : ST_ZERO;
        end
      end

      // inf / nan text, always lower case
      ST_SPEC0: begin
        if (slot_free) begin
          out_valid_next = 1'b1;
          out_char_next  = is_nan ? CH_N : CH_I;
          out_last_next  = 1'b0;
          state_next     = ST_SPEC1;
        end
      end

      ST_SPEC1: begin
        if (slot_free) begin
          out_valid_next = 1'b1;
          out_char_next  = is_nan ? CH_LA : CH_N;
          out_last_next  = 1'b0;
          state_next     = ST_SPEC2;
        end
      end

      ST_SPEC2: begin
        if (slot_free) begin
          out_valid_next = 1'b1;
          out_char_next  = is_nan ? CH_N : CH_F;
          out_last_next  = 1'b1;
          state_next     = ST_IDLE;
        end
      end

      ST_ZERO: begin
        if (slot_free) begin
          out_valid_next = 1'b1;
          out_char_next  = CH_ZERO;
          out_last_next  = 1'b0;
          state_next     = ST_X;
        end
      end

      ST_X: begin
        if (slot_free) begin
          out_valid_next = 1'b1;
          out_char_next  = upper ? CH_UX : CH_LX;
          out_last_next  = 1'b0;
          state_next     = ST_LEAD;
        end
      end

      // leading digit, 0..2 after rounding carry
      ST_LEAD: begin
        if (slot_free) begin
          out_valid_next = 1'b1;
          out_char_next  = hex_char({2'b00, coeff[COEFF_W-1:FRAC_BITS]}, upper);
          out_last_next  = 1'b0;
          state_next     = show_point ? ST_POINT : ST_P;
        end
      end

      ST_POINT: begin
        if (slot_free) begin
          out_valid_next = 1'b1;
          out_char_next  = CH_POINT;
          out_last_next  = 1'b0;
          state_next     = has_digits ? ST_FRAC : ST_P;
        end
      end

      // fraction digits from the top nybble; zeros shift in past digit 13
      ST_FRAC: begin
        if (slot_free) begin
          out_valid_next = 1'b1;
          out_char_next  = hex_char(coeff[FRAC_BITS-1 -: 4], upper);
          out_last_next  = 1'b0;
          coeff_next[FRAC_BITS-1:0] = {coeff[FRAC_BITS-5:0], 4'h0};
          if (!shortest) begin
            cnt_next = cnt - 1'b1;
          end
          if (shortest ? (coeff[FRAC_BITS-5:0] == '0) : (cnt == CW'(1))) begin
            state_next = ST_P;
          end
        end
      end

      ST_P: begin
        if (slot_free) begin
          out_valid_next = 1'b1;
          out_char_next  = upper ? CH_UP : CH_LP;
          out_last_next  = 1'b0;
          state_next     = ST_ESIGN;
        end
      end

      // exponent sign; also line up the first significant bcd digit
      ST_ESIGN: begin
        if (slot_free) begin
          out_valid_next = 1'b1;
          out_char_next  = eneg ? CH_MINUS : CH_PLUS;
          out_last_next  = 1'b0;
          if (bcd[15:12] != '0) begin
            ecnt_next = 2'd3;
          end else if (bcd[11:8] != '0) begin
            ecnt_next = 2'd2;
            bcd_next  = {bcd[11:0], 4'h0};
          end else if (bcd[7:4] != '0) begin
            ecnt_next = 2'd1;
            bcd_next  = {bcd[7:0], 8'h00};
          end else begin
            ecnt_next = 2'd0;
            bcd_next  = {bcd[3:0], 12'h000};
          end
          state_next = ST_EDIG;
        end
      end

      ST_EDIG: begin
        if (slot_free) begin
          out_valid_next = 1'b1;
          out_char_next  = hex_char(bcd[BCD_W-1 -: 4], 1'b0);
          out_last_next  = (ecnt == 2'd0);
          bcd_next       = {bcd[BCD_W-5:0], 4'h0};
          ecnt_next      = ecnt - 1'b1;
          if (ecnt == 2'd0) begin
            state_next = ST_IDLE;
          end
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire
